// File: design/ntsp_pkg.sv
// Shared types and constants for the nearest-target shortest path block.
package ntsp_pkg;

    localparam int CITY_W = 6;
    localparam int CX     = CITY_W + 1;
    localparam int LEN_W  = 16;
    localparam int DOUT_W = 22;
    localparam int NC_W   = 7;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ROAD  = 2'd1;
    localparam logic [1:0] MODE_FLAG  = 2'd2;
    localparam logic [1:0] MODE_QUERY = 2'd3;

    localparam logic [1:0] ST_PATH     = 2'd0;
    localparam logic [1:0] ST_NO_TGT   = 2'd1;
    localparam logic [1:0] ST_BAD_START = 2'd2;

    typedef struct packed {
        logic              clear;
        logic              add;
        logic              set_flag;
        logic [CITY_W-1:0] city_a;
        logic [CITY_W-1:0] city_b;
        logic [LEN_W-1:0]  length;
        logic              flag;
    } graph_cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [CITY_W-1:0] city;
        logic [DOUT_W-1:0] total;
        logic              last;
    } result_t;

endpackage

// File: design/nearest_target_shortest_path.sv
// Top level of the nearest-target shortest path block.
//
//  channel  | direction | contents
//  s_axis   | in        | tuser: mode; tdata: city_a, city_b, road_length, has_target
//  m_axis   | out       | tuser: status; tdata: path_city, path_distance; tlast: last
//  cfg      | in        | num_cities, written when cfg_wr_en is high
//
// Clear, add-road and set-flag items leave s_axis_tready high.
// A query runs Dijkstra from the start city: each visit scans the road store
// through one memory port, then the cities are scanned with the shared
// comparator to pick the next city and, at the end, the nearest target.
// s_axis_tready is low while a query runs; one output register parts the
// result side, so a stalled m_axis holds the sequencer only at emission.
// rst_n clears control state, the road count and the flags, and sets num_cities to 64.
module nearest_target_shortest_path
    import ntsp_pkg::*;
#(
    parameter int MAX_CITIES  = 64,
    parameter int MAX_ROADS   = 256,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [31:0]     s_axis_tdata,   // city_a, city_b, road_length, has_target
    input  logic [1:0]      s_axis_tuser,   // mode
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [31:0]     m_axis_tdata,   // path_city, path_distance
    output logic [1:0]      m_axis_tuser,   // status
    output logic            m_axis_tlast,
    input  logic            cfg_wr_en,
    input  logic [NC_W-1:0] cfg_wr_data     // num_cities
);

    localparam int CW = $clog2(MAX_CITIES);
    localparam int NW = CW + 1;
    localparam int RA = (MAX_ROADS > 1) ? $clog2(MAX_ROADS) : 1;
    localparam int RW = $clog2(MAX_ROADS+1);

    logic [NC_W-1:0]       nc_reg;
    logic [NW-1:0]         n_eff;
    logic                  acc;
    graph_cmd_t            cmd;
    logic [RA-1:0]         road_addr;
    logic [CITY_W-1:0]     road_a, road_b;
    logic [WEIGHT_BITS-1:0] road_w;
    logic [RW-1:0]         road_count;
    logic [MAX_CITIES-1:0] flags;
    logic                  busy;
    logic                  res_valid;
    logic                  slot_free;
    result_t               res;
    logic                  ov_reg;
    result_t               out_reg;

    // city count clamp: 0 acts as 1, above the array acts as full
    always_comb
    begin
        if (nc_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (nc_reg > NC_W'(MAX_CITIES))
        begin
            n_eff = NW'(MAX_CITIES);
        end
        else
        begin
            n_eff = NW'(nc_reg);
        end
    end

    assign s_axis_tready = !busy;
    assign acc           = s_axis_tvalid && s_axis_tready;

    assign cmd.clear    = acc && (s_axis_tuser == MODE_CLEAR);
    assign cmd.add      = acc && (s_axis_tuser == MODE_ROAD);
    assign cmd.set_flag = acc && (s_axis_tuser == MODE_FLAG);
    assign cmd.city_a   = s_axis_tdata[5:0];
    assign cmd.city_b   = s_axis_tdata[11:6];
    assign cmd.length   = s_axis_tdata[27:12];
    assign cmd.flag     = s_axis_tdata[28];

    ntsp_graph #(
        .MAX_CITIES  (MAX_CITIES),
        .MAX_ROADS   (MAX_ROADS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_graph (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .road_addr  (road_addr),
        .road_a     (road_a),
        .road_b     (road_b),
        .road_w     (road_w),
        .road_count (road_count),
        .flags      (flags)
    );

    ntsp_search #(
        .MAX_CITIES  (MAX_CITIES),
        .MAX_ROADS   (MAX_ROADS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (acc && (s_axis_tuser == MODE_QUERY)),
        .start_city (s_axis_tdata[5:0]),
        .n_cities   (n_eff),
        .road_addr  (road_addr),
        .road_a     (road_a),
        .road_b     (road_b),
        .road_w     (road_w),
        .road_count (road_count),
        .flags      (flags),
        .busy       (busy),
        .res_valid  (res_valid),
        .res_ready  (slot_free),
        .res        (res)
    );

    // output register
    assign slot_free = !ov_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            nc_reg <= NC_W'(64);
        end
        else
        begin
            if (slot_free)
            begin
                ov_reg <= res_valid;
            end
            if (cfg_wr_en)
            begin
                nc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {4'b0, out_reg.total, out_reg.city};
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tlast  = out_reg.last;

    // a status result is always the only one of its query
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_PATH) |-> m_axis_tlast)
        else $error("status result without last");

    // a query holds off the input for at least the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (s_axis_tuser == MODE_QUERY) |=> !s_axis_tready)
        else $error("input ready right after query");

    // path cities lie inside the city count in use
    a_city_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_PATH) |->
            (CX'(m_axis_tdata[5:0]) < CX'(n_eff)))
        else $error("path city out of range");

endmodule

// File: design/ntsp_graph.sv
// Road store, road count and target flags.
module ntsp_graph
    import ntsp_pkg::*;
#(
    parameter int MAX_CITIES  = 64,
    parameter int MAX_ROADS   = 256,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  graph_cmd_t                           cmd,
    input  logic [(MAX_ROADS > 1 ? $clog2(MAX_ROADS) : 1)-1:0] road_addr,
    output logic [CITY_W-1:0]                    road_a,
    output logic [CITY_W-1:0]                    road_b,
    output logic [WEIGHT_BITS-1:0]               road_w,
    output logic [$clog2(MAX_ROADS+1)-1:0]       road_count,
    output logic [MAX_CITIES-1:0]                flags
);

    localparam int RA = (MAX_ROADS > 1) ? $clog2(MAX_ROADS) : 1;
    localparam int RW = $clog2(MAX_ROADS+1);
    localparam int EW = 2*CITY_W + WEIGHT_BITS;

    logic [EW-1:0]       road_mem [MAX_ROADS];
    logic [EW-1:0]       road_q_reg;
    logic [RW-1:0]       count_reg;
    logic [RW-1:0]       count_next;
    logic [MAX_CITIES-1:0] flags_reg;
    logic [MAX_CITIES-1:0] flags_next;
    logic                store_en;
    logic [LEN_W+WEIGHT_BITS-1:0] len_wide;

    assign len_wide = (LEN_W+WEIGHT_BITS)'(cmd.length);
    assign store_en = cmd.add && (count_reg < RW'(MAX_ROADS));

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            road_mem[count_reg[RA-1:0]] <= {len_wide[WEIGHT_BITS-1:0], cmd.city_b, cmd.city_a};
        end
        road_q_reg <= road_mem[road_addr];
    end

    always_comb
    begin
        count_next = count_reg;
        flags_next = flags_reg;
        if (cmd.clear)
        begin
            count_next = '0;
            flags_next = '0;
        end
        else if (store_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.set_flag && (CX'(cmd.city_a) < CX'(MAX_CITIES)))
        begin
            flags_next[cmd.city_a[$clog2(MAX_CITIES)-1:0]] = cmd.flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flags_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            flags_reg <= flags_next;
        end
    end

    assign road_a     = road_q_reg[CITY_W-1:0];
    assign road_b     = road_q_reg[2*CITY_W-1:CITY_W];
    assign road_w     = road_q_reg[EW-1:2*CITY_W];
    assign road_count = count_reg;
    assign flags      = flags_reg;

endmodule

// File: design/ntsp_search.sv
// Search sequencer: Dijkstra over the road store with one shared comparator.
module ntsp_search
    import ntsp_pkg::*;
#(
    parameter int MAX_CITIES  = 64,
    parameter int MAX_ROADS   = 256,
    parameter int WEIGHT_BITS = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [CITY_W-1:0]                    start_city,
    input  logic [$clog2(MAX_CITIES):0]          n_cities,
    output logic [(MAX_ROADS > 1 ? $clog2(MAX_ROADS) : 1)-1:0] road_addr,
    input  logic [CITY_W-1:0]                    road_a,
    input  logic [CITY_W-1:0]                    road_b,
    input  logic [WEIGHT_BITS-1:0]               road_w,
    input  logic [$clog2(MAX_ROADS+1)-1:0]       road_count,
    input  logic [MAX_CITIES-1:0]                flags,
    output logic                                 busy,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output result_t                              res
);

    localparam int CW = $clog2(MAX_CITIES);
    localparam int NW = CW + 1;
    localparam int DW = WEIGHT_BITS + CW;
    localparam int RA = (MAX_ROADS > 1) ? $clog2(MAX_ROADS) : 1;
    localparam int RW = $clog2(MAX_ROADS+1);
    localparam logic [DW-1:0] INF = '1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INIT  = 4'd1;
    localparam logic [3:0] S_VISIT = 4'd2;
    localparam logic [3:0] S_ROAD  = 4'd3;
    localparam logic [3:0] S_REL   = 4'd4;
    localparam logic [3:0] S_SEL   = 4'd5;
    localparam logic [3:0] S_TGT   = 4'd6;
    localparam logic [3:0] S_PRD   = 4'd7;
    localparam logic [3:0] S_PWT   = 4'd8;
    localparam logic [3:0] S_ERD   = 4'd9;
    localparam logic [3:0] S_EOUT  = 4'd10;
    localparam logic [3:0] S_STAT  = 4'd11;

    logic [3:0]            state_reg, state_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [NW-1:0]         idx_reg, idx_next;
    logic [NW-1:0]         iter_reg, iter_next;
    logic [NW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         start_reg, start_next;
    logic [CW-1:0]         v_reg, v_next;
    logic [CW-1:0]         u_reg, u_next;
    logic [CW-1:0]         to_reg, to_next;
    logic [CW-1:0]         bidx_reg, bidx_next;
    logic [DW-1:0]         cur_reg, cur_next;
    logic [DW-1:0]         best_reg, best_next;
    logic                  found_reg, found_next;
    logic [RW-1:0]         ridx_reg, ridx_next;
    logic [1:0]            stat_reg, stat_next;
    logic [MAX_CITIES-1:0] vis_reg, vis_next;

    logic [DW-1:0]         dist_mem [MAX_CITIES];
    logic [CW:0]           pred_mem [MAX_CITIES];
    logic [CW-1:0]         stack_mem [MAX_CITIES];
    logic [DW-1:0]         dist_q;
    logic [CW:0]           pred_q;
    logic [CW-1:0]         stack_q;

    logic                  dist_we, pred_we, stack_we;
    logic [CW-1:0]         dist_wa, dist_ra, pred_wa, stack_wa, stack_ra;
    logic [DW-1:0]         dist_wd;
    logic [CW:0]           pred_wd;

    // shared comparator
    logic [DW:0]           cmp_x, cmp_y;
    logic                  lt;

    logic [CW-1:0]         p;
    logic                  hit_a, hit_b;
    logic [CITY_W-1:0]     other;
    logic                  rel_go;
    logic                  scan_take;
    logic                  f_now;
    logic [DW-1:0]         b_now;
    logic [CW-1:0]         bi_now;
    logic [NW-1:0]         ridx_inc;

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[dist_wa] <= dist_wd;
        end
        if (pred_we)
        begin
            pred_mem[pred_wa] <= pred_wd;
        end
        if (stack_we)
        begin
            stack_mem[stack_wa] <= u_reg;
        end
        dist_q  <= dist_mem[dist_ra];
        pred_q  <= pred_mem[u_reg];
        stack_q <= stack_mem[stack_ra];
    end

    assign p      = CW'(idx_reg - 1'b1);
    assign hit_a  = (road_a == CITY_W'(v_reg));
    assign hit_b  = (road_b == CITY_W'(v_reg));
    assign other  = hit_a ? road_b : road_a;
    assign rel_go = (hit_a || hit_b) && (road_a != road_b) && (CX'(other) < CX'(n_reg));
    assign ridx_inc = NW'(0);

    always_comb
    begin
        if (state_reg == S_REL)
        begin
            cmp_x = {1'b0, cur_reg} + (DW+1)'(road_w);
            cmp_y = {1'b0, dist_q};
        end
        else
        begin
            cmp_x = {1'b0, dist_q};
            cmp_y = {1'b0, best_reg};
        end
    end
    assign lt = cmp_x < cmp_y;

    assign scan_take = (idx_reg != '0) && lt &&
                       ((state_reg == S_SEL) ? !vis_reg[p] : flags[p]);
    assign f_now  = found_reg || scan_take;
    assign b_now  = scan_take ? dist_q : best_reg;
    assign bi_now = scan_take ? p : bidx_reg;

    // a road that relaxes stays on the read port so its weight is there in S_REL
    assign road_addr = (state_reg == S_VISIT) ? '0 :
                       ((state_reg == S_ROAD) && rel_go) ? RA'(ridx_reg) :
                       RA'(ridx_reg + 1'b1);
    assign dist_ra   = (state_reg == S_ROAD) ? CW'(other) : CW'(idx_reg);
    assign stack_ra  = CW'(idx_reg - 1'b1);

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        idx_next   = idx_reg;
        iter_next  = iter_reg;
        cnt_next   = cnt_reg;
        start_next = start_reg;
        v_next     = v_reg;
        u_next     = u_reg;
        to_next    = to_reg;
        bidx_next  = bidx_reg;
        cur_next   = cur_reg;
        best_next  = best_reg;
        found_next = found_reg;
        ridx_next  = ridx_reg;
        stat_next  = stat_reg;
        vis_next   = vis_reg;
        dist_we    = 1'b0;
        dist_wa    = CW'(idx_reg);
        dist_wd    = INF;
        pred_we    = 1'b0;
        pred_wa    = CW'(idx_reg);
        pred_wd    = {1'b1, {CW{1'b0}}};
        stack_we   = 1'b0;
        stack_wa   = CW'(cnt_reg);
        res_valid  = 1'b0;
        res        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = n_cities;
                    start_next = CW'(start_city);
                    idx_next   = '0;
                    vis_next   = '0;
                    if (CX'(start_city) >= CX'(n_cities))
                    begin
                        stat_next  = ST_BAD_START;
                        state_next = S_STAT;
                    end
                    else
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                dist_we  = 1'b1;
                dist_wd  = (CW'(idx_reg) == start_reg) ? '0 : INF;
                pred_we  = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == NW'(n_reg - 1'b1))
                begin
                    v_next     = start_reg;
                    cur_next   = '0;
                    iter_next  = '0;
                    state_next = S_VISIT;
                end
            end
            S_VISIT:
            begin
                vis_next[v_reg] = 1'b1;
                ridx_next       = '0;
                idx_next        = '0;
                best_next       = INF;
                found_next      = 1'b0;
                state_next      = (road_count == '0) ? S_SEL : S_ROAD;
            end
            S_ROAD:
            begin
                if (rel_go)
                begin
                    to_next    = CW'(other);
                    state_next = S_REL;
                end
                else if (ridx_reg == RW'(road_count - 1'b1))
                begin
                    state_next = S_SEL;
                end
                else
                begin
                    ridx_next = ridx_reg + 1'b1;
                end
            end
            S_REL:
            begin
                if (lt)
                begin
                    dist_we = 1'b1;
                    dist_wa = to_reg;
                    dist_wd = cmp_x[DW-1:0];
                    pred_we = 1'b1;
                    pred_wa = to_reg;
                    pred_wd = {1'b0, v_reg};
                end
                if (ridx_reg == RW'(road_count - 1'b1))
                begin
                    state_next = S_SEL;
                end
                else
                begin
                    ridx_next  = ridx_reg + 1'b1;
                    state_next = S_ROAD;
                end
            end
            S_SEL, S_TGT:
            begin
                best_next  = b_now;
                bidx_next  = bi_now;
                found_next = f_now;
                idx_next   = idx_reg + 1'b1;
                if (idx_reg == n_reg)
                begin
                    idx_next   = '0;
                    best_next  = INF;
                    found_next = 1'b0;
                    if (state_reg == S_TGT)
                    begin
                        best_next = b_now;
                        if (f_now)
                        begin
                            u_next     = bi_now;
                            cnt_next   = '0;
                            state_next = S_PRD;
                        end
                        else
                        begin
                            stat_next  = ST_NO_TGT;
                            state_next = S_STAT;
                        end
                    end
                    else if (f_now && (NW'(iter_reg + 1'b1) < n_reg))
                    begin
                        v_next     = bi_now;
                        cur_next   = b_now;
                        iter_next  = iter_reg + 1'b1;
                        state_next = S_VISIT;
                    end
                    else
                    begin
                        state_next = S_TGT;
                    end
                end
            end
            S_PRD:
            begin
                stack_we   = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_PWT;
            end
            S_PWT:
            begin
                if (pred_q[CW] || (NW'(pred_q[CW-1:0]) >= n_reg) || (cnt_reg == n_reg))
                begin
                    idx_next   = cnt_reg;
                    state_next = S_ERD;
                end
                else
                begin
                    u_next     = pred_q[CW-1:0];
                    state_next = S_PRD;
                end
            end
            S_ERD:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                res_valid  = 1'b1;
                res.status = ST_PATH;
                res.city   = CITY_W'(stack_q);
                res.total  = DOUT_W'(best_reg);
                res.last   = (idx_reg == NW'(1));
                if (res_ready)
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = (idx_reg == NW'(1)) ? S_IDLE : S_ERD;
                end
            end
            S_STAT:
            begin
                res_valid  = 1'b1;
                res.status = stat_reg;
                res.last   = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        idx_reg   <= idx_next + ridx_inc;
        iter_reg  <= iter_next;
        cnt_reg   <= cnt_next;
        start_reg <= start_next;
        v_reg     <= v_next;
        u_reg     <= u_next;
        to_reg    <= to_next;
        bidx_reg  <= bidx_next;
        cur_reg   <= cur_next;
        best_reg  <= best_next;
        found_reg <= found_next;
        ridx_reg  <= ridx_next;
        stat_reg  <= stat_next;
        vis_reg   <= vis_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule
